// ----- src/ps2mct_pkg.sv -----
// shared types and constants for the ps/2 mouse cursor tracker
// request and response payload structs, request codes, reset values
package ps2mct_pkg;

   localparam int unsigned POS_W      = 12;
   localparam int unsigned LIMIT_W    = 13;
   localparam int unsigned DEBOUNCE_W = 8;
   localparam int unsigned TICK_W     = 32;
   localparam int unsigned IDX_W      = 2;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 13;

   localparam logic [1:0] REQ_BYTE    = 2'd0;
   localparam logic [1:0] REQ_PRESS   = 2'd1;
   localparam logic [1:0] REQ_RELEASE = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEBOUNCE      = 2'd2;

   localparam logic [IDX_W-1:0] IDX_FLAGS = 2'd0;
   localparam logic [IDX_W-1:0] IDX_DX    = 2'd1;
   localparam logic [IDX_W-1:0] IDX_DY    = 2'd2;

   localparam logic [LIMIT_W-1:0]    LIMIT_MIN = 13'd1;
   localparam logic [LIMIT_W-1:0]    LIMIT_MAX = 13'd4096;

   localparam logic [LIMIT_W-1:0]    WIDTH_RESET    = 13'd800;
   localparam logic [LIMIT_W-1:0]    HEIGHT_RESET   = 13'd600;
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd10;
   localparam logic [POS_W-1:0]      POS_X_RESET    = 12'd400;
   localparam logic [POS_W-1:0]      POS_Y_RESET    = 12'd300;

   localparam int unsigned LEFT_BUTTON_BIT = 0;

   typedef struct packed {
      logic [1:0]        req_type;
      logic              out_full;
      logic              aux_data;
      logic [7:0]        data_byte;
      logic [TICK_W-1:0] now_ticks;
   } req_type_type;

   typedef struct packed {
      logic [POS_W-1:0] cursor_x;
      logic [POS_W-1:0] cursor_y;
      logic             left_held;
      logic             packet_done;
      logic             press_event;
      logic             release_event;
   } rsp_type;

endpackage

// ----- src/ps2mct_axis.sv -----
// one cursor axis update: position plus signed delta, clamped to 0..limit-1, with limit first clamped to 1..4096
// depends on ps2mct_pkg
module ps2mct_axis (
   input  logic [ps2mct_pkg::POS_W-1:0]   pos,
   input  logic signed [8:0]              delta,
   input  logic [ps2mct_pkg::LIMIT_W-1:0] limit,
   output logic [ps2mct_pkg::POS_W-1:0]   pos_next
);

   logic [ps2mct_pkg::LIMIT_W-1:0] lim_eff;
   logic [ps2mct_pkg::LIMIT_W-1:0] top;
   logic signed [13:0]             sum;

   always_comb begin
      if (limit == '0) begin
         lim_eff = ps2mct_pkg::LIMIT_MIN;
      end else if (limit > ps2mct_pkg::LIMIT_MAX) begin
         lim_eff = ps2mct_pkg::LIMIT_MAX;
      end else begin
         lim_eff = limit;
      end
      top = lim_eff - ps2mct_pkg::LIMIT_MIN;
      sum = $signed({2'b00, pos}) + $signed({{5{delta[8]}}, delta});
      if (sum[13]) begin
         pos_next = '0;
      end else if (sum[12:0] > top) begin
         pos_next = top[ps2mct_pkg::POS_W-1:0];
      end else begin
         pos_next = sum[ps2mct_pkg::POS_W-1:0];
      end
   end

endmodule

// ----- src/ps2_mouse_cursor_tracker_core.sv -----
// ps/2 mouse cursor tracker: three-byte packet assembly, cursor clamp, button edges
// depends on ps2mct_pkg and ps2mct_axis
// response path: an accepted request goes to the request register, then to the response register
// throughput: one request per cycle while responses are taken; while a response waits,
// the request register takes one more request, and then both registers are full
// reset: synchronous, cursor at 400,300, limits 800x600, debounce 10, packet index 0
module ps2_mouse_cursor_tracker_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  ps2mct_pkg::req_type_type            req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ps2mct_pkg::rsp_type                 rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ps2mct_pkg::CSR_ADDR_W-1:0]   csr_index,
   input  logic [ps2mct_pkg::CSR_DATA_W-1:0]   csr_data
);

   logic                                 in_valid_ff, in_valid_in;
   ps2mct_pkg::req_type_type             in_data_ff;
   logic                                 rsp_valid_ff, rsp_valid_in;
   ps2mct_pkg::rsp_type                  rsp_data_ff, rsp_data_in;

   logic [ps2mct_pkg::LIMIT_W-1:0]       width_ff, width_in;
   logic [ps2mct_pkg::LIMIT_W-1:0]       height_ff, height_in;
   logic [ps2mct_pkg::DEBOUNCE_W-1:0]    debounce_ff, debounce_in;

   logic [ps2mct_pkg::POS_W-1:0]         pos_x_ff, pos_x_in;
   logic [ps2mct_pkg::POS_W-1:0]         pos_y_ff, pos_y_in;
   logic [ps2mct_pkg::IDX_W-1:0]         byte_idx_ff, byte_idx_in;
   logic [7:0]                           flags_ff, flags_in;
   logic [7:0]                           dx_ff, dx_in;
   logic                                 btn_now_ff, btn_now_in;
   logic                                 btn_before_ff, btn_before_in;
   logic [ps2mct_pkg::TICK_W-1:0]        last_press_ff, last_press_in;

   logic                                 advance;
   logic                                 req_fire;
   logic signed [8:0]                    delta_x;
   logic signed [8:0]                    delta_y;
   logic [ps2mct_pkg::POS_W-1:0]         new_x;
   logic [ps2mct_pkg::POS_W-1:0]         new_y;
   logic [ps2mct_pkg::IDX_W-1:0]         idx_cur;
   logic [ps2mct_pkg::TICK_W-1:0]        since_press;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   assign delta_x = $signed({dx_ff[7], dx_ff});
   assign delta_y = -$signed({in_data_ff.data_byte[7], in_data_ff.data_byte});

   ps2mct_axis u_axis_x (
      .pos      (pos_x_ff),
      .delta    (delta_x),
      .limit    (width_ff),
      .pos_next (new_x)
   );

   ps2mct_axis u_axis_y (
      .pos      (pos_y_ff),
      .delta    (delta_y),
      .limit    (height_ff),
      .pos_next (new_y)
   );

   always_comb begin
      in_valid_in   = in_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      debounce_in   = debounce_ff;
      pos_x_in      = pos_x_ff;
      pos_y_in      = pos_y_ff;
      byte_idx_in   = byte_idx_ff;
      flags_in      = flags_ff;
      dx_in         = dx_ff;
      btn_now_in    = btn_now_ff;
      btn_before_in = btn_before_ff;
      last_press_in = last_press_ff;
      idx_cur       = (byte_idx_ff > ps2mct_pkg::IDX_DY) ? ps2mct_pkg::IDX_FLAGS : byte_idx_ff;
      since_press   = in_data_ff.now_ticks - last_press_ff;

      if (csr_valid) begin
         unique case (csr_index)
            ps2mct_pkg::CSR_SCREEN_WIDTH:  width_in    = csr_data;
            ps2mct_pkg::CSR_SCREEN_HEIGHT: height_in   = csr_data;
            ps2mct_pkg::CSR_DEBOUNCE:      debounce_in = csr_data[ps2mct_pkg::DEBOUNCE_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (advance) begin
         in_valid_in                 = 1'b0;
         rsp_valid_in                = 1'b1;
         rsp_data_in.packet_done     = 1'b0;
         rsp_data_in.press_event     = 1'b0;
         rsp_data_in.release_event   = 1'b0;
         unique case (in_data_ff.req_type)
            ps2mct_pkg::REQ_BYTE: begin
               if (in_data_ff.out_full && in_data_ff.aux_data) begin
                  unique case (idx_cur)
                     ps2mct_pkg::IDX_FLAGS: begin
                        flags_in    = in_data_ff.data_byte;
                        byte_idx_in = ps2mct_pkg::IDX_DX;
                     end
                     ps2mct_pkg::IDX_DX: begin
                        dx_in       = in_data_ff.data_byte;
                        byte_idx_in = ps2mct_pkg::IDX_DY;
                     end
                     default: begin
                        pos_x_in                = new_x;
                        pos_y_in                = new_y;
                        btn_now_in              = flags_ff[ps2mct_pkg::LEFT_BUTTON_BIT];
                        byte_idx_in             = ps2mct_pkg::IDX_FLAGS;
                        rsp_data_in.packet_done = 1'b1;
                     end
                  endcase
               end
            end
            ps2mct_pkg::REQ_PRESS: begin
               if (btn_now_ff && !btn_before_ff) begin
                  if (since_press >= {{(ps2mct_pkg::TICK_W - ps2mct_pkg::DEBOUNCE_W){1'b0}},
                                      debounce_ff}) begin
                     rsp_data_in.press_event = 1'b1;
                     last_press_in           = in_data_ff.now_ticks;
                     btn_before_in           = btn_now_ff;
                  end
               end else begin
                  btn_before_in = btn_now_ff;
               end
            end
            ps2mct_pkg::REQ_RELEASE: begin
               rsp_data_in.release_event = !btn_now_ff && btn_before_ff;
               btn_before_in             = btn_now_ff;
            end
            default: ;
         endcase
         rsp_data_in.cursor_x  = pos_x_in;
         rsp_data_in.cursor_y  = pos_y_in;
         rsp_data_in.left_held = btn_now_in;
      end

      if (req_fire) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         width_ff      <= ps2mct_pkg::WIDTH_RESET;
         height_ff     <= ps2mct_pkg::HEIGHT_RESET;
         debounce_ff   <= ps2mct_pkg::DEBOUNCE_RESET;
         pos_x_ff      <= ps2mct_pkg::POS_X_RESET;
         pos_y_ff      <= ps2mct_pkg::POS_Y_RESET;
         byte_idx_ff   <= ps2mct_pkg::IDX_FLAGS;
         btn_now_ff    <= 1'b0;
         btn_before_ff <= 1'b0;
         last_press_ff <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         debounce_ff   <= debounce_in;
         pos_x_ff      <= pos_x_in;
         pos_y_ff      <= pos_y_in;
         byte_idx_ff   <= byte_idx_in;
         btn_now_ff    <= btn_now_in;
         btn_before_ff <= btn_before_in;
         last_press_ff <= last_press_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_payload;
      end
      rsp_data_ff <= rsp_data_in;
      flags_ff    <= flags_in;
      dx_ff       <= dx_in;
   end

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      byte_idx_ff != 2'd3)
      else $error("packet byte index out of range");

   a_done_no_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.packet_done |->
         !rsp_data_ff.press_event && !rsp_data_ff.release_event)
      else $error("packet completion flagged together with a button event");

   a_one_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.press_event && rsp_data_ff.release_event))
      else $error("press and release reported on one response");

   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> in_valid_ff)
      else $error("accepted request lost from request register");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff))
      else $error("stalled request changed before it was processed");

endmodule
